@@ design/tcp_client_connection_fsm_top_assert.svh @@
// Assertion macros for the TCP client connection block
`ifndef TCP_CLIENT_CONNECTION_FSM_TOP_ASSERT_SVH
`define TCP_CLIENT_CONNECTION_FSM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TCC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcc assertion failed");
`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcc assertion failed");
`else
`define TCC_ASSERT_NOW(label, clk, rst, ante, cons)
`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/tcc_pkg.sv @@
// Shared types and constants for the TCP client connection block
`default_nettype none
package tcc_pkg;

  localparam logic [3:0] ST_START        = 4'd0;
  localparam logic [3:0] ST_SYN_SENT     = 4'd1;
  localparam logic [3:0] ST_SYN_RECEIVED = 4'd2;
  localparam logic [3:0] ST_ESTABLISHED  = 4'd3;
  localparam logic [3:0] ST_FIN_WAIT1    = 4'd4;
  localparam logic [3:0] ST_FIN_WAIT2    = 4'd5;
  localparam logic [3:0] ST_CLOSE_WAIT   = 4'd6;
  localparam logic [3:0] ST_CLOSING      = 4'd7;
  localparam logic [3:0] ST_LAST_ACK     = 4'd8;
  localparam logic [3:0] ST_TIME_WAIT    = 4'd9;
  localparam logic [3:0] ST_CLOSED       = 4'd10;

  localparam logic OP_OPEN    = 1'b0;
  localparam logic OP_SEGMENT = 1'b1;

  localparam logic [1:0] REG_LOCAL_PORT     = 2'd0;
  localparam logic [1:0] REG_INITIAL_SEQ    = 2'd1;
  localparam logic [1:0] REG_REQUEST_LENGTH = 2'd2;
  localparam logic [1:0] REG_MAX_TRIES      = 2'd3;

  localparam logic [15:0] RST_LOCAL_PORT     = 16'd4000;
  localparam logic [10:0] RST_REQUEST_LENGTH = 11'd45;
  localparam logic [5:0]  RST_MAX_TRIES      = 6'd20;

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int CNT_W     = 3;

  typedef struct packed {
    logic [15:0] local_port;
    logic [31:0] initial_seq;
    logic [10:0] request_length;
    logic [5:0]  max_tries;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic        in_syn;
    logic        in_ack_flag;
    logic        in_fin;
    logic [31:0] in_seq;
    logic [31:0] in_ack_num;
    logic [10:0] in_payload_len;
    logic [15:0] in_dest_port;
  } item_t;

  typedef struct packed {
    logic [3:0]  fsm_state;
    logic [31:0] local_seq;
    logic [31:0] fin_seq;
    logic [31:0] remote_seq;
    logic [31:0] last_ack_seen;
    logic [5:0]  step_count;
    logic        done;
  } ctx_t;

  typedef struct packed {
    logic        out_syn;
    logic        out_ack;
    logic        out_fin;
    logic        out_psh;
    logic [31:0] out_seq;
    logic [31:0] out_ack_num;
    logic [10:0] out_payload_len;
    logic        out_last;
    logic        finished;
    logic [3:0]  conn_state;
  } beat_t;

  typedef struct packed {
    logic       upd;
    logic [1:0] n;
    beat_t      beat0;
    beat_t      beat1;
    ctx_t       ctx_next;
  } step_t;

endpackage
`default_nettype wire

@@ design/tcc_step.sv @@
// One connection step: state update and up to two outgoing segment beats
`default_nettype none
module tcc_step (
  input  tcc_pkg::cfg_t  cfg,
  input  tcc_pkg::ctx_t  ctx,
  input  tcc_pkg::item_t item,
  output tcc_pkg::step_t step
);

  always_comb begin
    logic [31:0] lseq;
    logic [31:0] lack;
    logic [31:0] rseq;
    logic [31:0] finq;
    logic [31:0] base;
    logic [5:0]  cnt;
    logic [3:0]  st;
    logic [1:0]  n;
    logic        act;
    logic        syn_e;
    logic        fin_e;
    logic        psh_e;
    logic        done_n;

    lseq  = ctx.local_seq;
    lack  = ctx.last_ack_seen;
    rseq  = ctx.remote_seq;
    finq  = ctx.fin_seq;
    cnt   = ctx.step_count;
    st    = ctx.fsm_state;
    n     = 2'd0;
    act   = 1'b0;
    syn_e = 1'b0;
    fin_e = 1'b0;
    psh_e = 1'b0;

    if (item.opcode == tcc_pkg::OP_OPEN) begin
      if (ctx.fsm_state == tcc_pkg::ST_START || ctx.done) begin
        act   = 1'b1;
        st    = tcc_pkg::ST_SYN_SENT;
        lseq  = cfg.initial_seq;
        finq  = '0;
        rseq  = '0;
        lack  = '0;
        cnt   = '0;
        n     = 2'd1;
        syn_e = 1'b1;
      end
    end else if (ctx.fsm_state != tcc_pkg::ST_START && !ctx.done &&
                 item.in_dest_port == cfg.local_port) begin
      act  = 1'b1;
      rseq = item.in_seq + 32'(item.in_payload_len) + 32'(item.in_syn) + 32'(item.in_fin);
      if (item.in_ack_flag) begin
        lack = item.in_ack_num;
        lseq = item.in_ack_num;
      end
      unique case (ctx.fsm_state)
        tcc_pkg::ST_SYN_SENT: begin
          if (item.in_syn) begin
            if (item.in_ack_flag) begin
              st    = tcc_pkg::ST_ESTABLISHED;
              n     = 2'd2;
              psh_e = 1'b1;
            end else begin
              st = tcc_pkg::ST_SYN_RECEIVED;
              n  = 2'd1;
            end
          end
        end
        tcc_pkg::ST_SYN_RECEIVED: begin
          if (item.in_ack_flag) begin
            st    = tcc_pkg::ST_ESTABLISHED;
            n     = 2'd1;
            psh_e = 1'b1;
          end
        end
        tcc_pkg::ST_ESTABLISHED: begin
          n = 2'd1;
          if (item.in_fin) begin
            st    = tcc_pkg::ST_CLOSE_WAIT;
            fin_e = 1'b1;
          end else if (lack <= cfg.initial_seq + 32'd1) begin
            psh_e = 1'b1;
          end else begin
            st    = tcc_pkg::ST_FIN_WAIT1;
            fin_e = 1'b1;
          end
        end
        tcc_pkg::ST_FIN_WAIT1: begin
          if (item.in_fin) begin
            st = tcc_pkg::ST_CLOSING;
            n  = 2'd1;
          end else if (lack > ctx.fin_seq) begin
            st = tcc_pkg::ST_FIN_WAIT2;
          end
        end
        tcc_pkg::ST_FIN_WAIT2: begin
          if (item.in_fin) begin
            st = tcc_pkg::ST_TIME_WAIT;
          end
          n = 2'd1;
        end
        tcc_pkg::ST_CLOSE_WAIT: begin
          st    = tcc_pkg::ST_LAST_ACK;
          n     = 2'd1;
          fin_e = 1'b1;
        end
        tcc_pkg::ST_LAST_ACK: begin
          if (item.in_ack_flag) begin
            st = tcc_pkg::ST_CLOSED;
          end
        end
        default: begin
        end
      endcase
    end

    // every beat of a step carries the same sequence number
    base = lseq;
    if (fin_e) begin
      finq = base + 32'd1;
    end
    lseq = base + 32'(syn_e | fin_e) + (psh_e ? 32'(cfg.request_length) : 32'd0);
    cnt  = cnt + 6'd1;
    done_n = ctx.done;
    if (act) begin
      done_n = st == tcc_pkg::ST_TIME_WAIT || st == tcc_pkg::ST_CLOSED ||
               st == tcc_pkg::ST_CLOSING || cnt >= cfg.max_tries;
    end

    step.upd = act;
    step.n   = n;

    step.beat0.out_syn         = syn_e;
    step.beat0.out_ack         = !syn_e;
    step.beat0.out_fin         = fin_e;
    step.beat0.out_psh         = psh_e && n == 2'd1;
    step.beat0.out_seq         = base;
    step.beat0.out_ack_num     = rseq;
    step.beat0.out_payload_len = (psh_e && n == 2'd1) ? cfg.request_length : 11'd0;
    step.beat0.out_last        = n == 2'd1;
    step.beat0.finished        = done_n;
    step.beat0.conn_state      = st;

    step.beat1.out_syn         = 1'b0;
    step.beat1.out_ack         = 1'b1;
    step.beat1.out_fin         = 1'b0;
    step.beat1.out_psh         = 1'b1;
    step.beat1.out_seq         = base;
    step.beat1.out_ack_num     = rseq;
    step.beat1.out_payload_len = cfg.request_length;
    step.beat1.out_last        = 1'b1;
    step.beat1.finished        = done_n;
    step.beat1.conn_state      = st;

    step.ctx_next.fsm_state     = st;
    step.ctx_next.local_seq     = lseq;
    step.ctx_next.fin_seq       = finq;
    step.ctx_next.remote_seq    = rseq;
    step.ctx_next.last_ack_seen = lack;
    step.ctx_next.step_count    = cnt;
    step.ctx_next.done          = done_n;
  end

endmodule
`default_nettype wire

@@ design/tcc_out_fifo.sv @@
// Result queue: takes up to two beats per cycle, hands out one
`default_nettype none
module tcc_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  tcc_pkg::beat_t    push0,
  input  tcc_pkg::beat_t    push1,
  input  logic              pop,
  output tcc_pkg::beat_t    head,
  output logic              not_empty,
  output logic              room
);

  tcc_pkg::beat_t mem [tcc_pkg::OUT_DEPTH];
  logic [tcc_pkg::PTR_W-1:0] wr_ptr;
  logic [tcc_pkg::PTR_W-1:0] rd_ptr;
  logic [tcc_pkg::CNT_W-1:0] count;
  logic [tcc_pkg::CNT_W-1:0] count_next;

  assign not_empty  = count != '0;
  assign room       = count <= tcc_pkg::CNT_W'(tcc_pkg::OUT_DEPTH - 2);
  assign head       = mem[rd_ptr];
  assign count_next = count + tcc_pkg::CNT_W'(push_n) - tcc_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tcc_pkg::PTR_W'(push_n);
      rd_ptr <= rd_ptr + tcc_pkg::PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + tcc_pkg::PTR_W'(1)] <= push1;
    end
  end

endmodule
`default_nettype wire

@@ design/tcp_client_connection_fsm_top.sv @@
// Top level of the TCP client connection block: input register, step logic, result queue.
// An item is registered on accept and its beats enter the queue once it has room for two beats,
// so with an empty queue they are written without waiting on the consumer. One item per cycle
// is taken while the four-entry result queue has room for two beats; drain sets the rate.
// Synchronous reset clears connection state, queue pointers and loads register defaults.
`default_nettype none
`include "tcp_client_connection_fsm_top_assert.svh"
module tcp_client_connection_fsm_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        opcode,
  input  logic        in_syn,
  input  logic        in_ack_flag,
  input  logic        in_fin,
  input  logic [31:0] in_seq,
  input  logic [31:0] in_ack_num,
  input  logic [10:0] in_payload_len,
  input  logic [15:0] in_dest_port,
  output logic        seg_valid,
  input  logic        seg_ready,
  output logic        out_syn,
  output logic        out_ack,
  output logic        out_fin,
  output logic        out_psh,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack_num,
  output logic [10:0] out_payload_len,
  output logic        out_last,
  output logic        finished,
  output logic [3:0]  conn_state
);

  tcc_pkg::cfg_t  cfg;
  tcc_pkg::ctx_t  ctx;
  tcc_pkg::item_t item;
  tcc_pkg::step_t step;
  tcc_pkg::beat_t head;
  logic           in_full;
  logic           room;
  logic           proc;

  assign proc       = in_full && room;
  assign item_ready = !in_full || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_port     <= tcc_pkg::RST_LOCAL_PORT;
      cfg.initial_seq    <= '0;
      cfg.request_length <= tcc_pkg::RST_REQUEST_LENGTH;
      cfg.max_tries      <= tcc_pkg::RST_MAX_TRIES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcc_pkg::REG_LOCAL_PORT:     cfg.local_port     <= cfg_data[15:0];
        tcc_pkg::REG_INITIAL_SEQ:    cfg.initial_seq    <= cfg_data;
        tcc_pkg::REG_REQUEST_LENGTH: cfg.request_length <= cfg_data[10:0];
        tcc_pkg::REG_MAX_TRIES:      cfg.max_tries      <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item.opcode         <= opcode;
      item.in_syn         <= in_syn;
      item.in_ack_flag    <= in_ack_flag;
      item.in_fin         <= in_fin;
      item.in_seq         <= in_seq;
      item.in_ack_num     <= in_ack_num;
      item.in_payload_len <= in_payload_len;
      item.in_dest_port   <= in_dest_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
    end else if (proc && step.upd) begin
      ctx <= step.ctx_next;
    end
  end

  tcc_step u_step (
    .cfg  (cfg),
    .ctx  (ctx),
    .item (item),
    .step (step)
  );

  tcc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (proc ? step.n : 2'd0),
    .push0     (step.beat0),
    .push1     (step.beat1),
    .pop       (seg_valid && seg_ready),
    .head      (head),
    .not_empty (seg_valid),
    .room      (room)
  );

  assign out_syn         = head.out_syn;
  assign out_ack         = head.out_ack;
  assign out_fin         = head.out_fin;
  assign out_psh         = head.out_psh;
  assign out_seq         = head.out_seq;
  assign out_ack_num     = head.out_ack_num;
  assign out_payload_len = head.out_payload_len;
  assign out_last        = head.out_last;
  assign finished        = head.finished;
  assign conn_state      = head.conn_state;

  `TCC_ASSERT_NOW(a_two_beat_last, clk, rst, proc && step.n == 2'd2,
    !step.beat0.out_last && step.beat1.out_last)
  `TCC_ASSERT_NEXT(a_open_syn_sent, clk, rst,
    proc && step.upd && item.opcode == tcc_pkg::OP_OPEN,
    ctx.fsm_state == tcc_pkg::ST_SYN_SENT && ctx.step_count == 6'd1)
  `TCC_ASSERT_NEXT(a_done_sticky, clk, rst,
    ctx.done && !(proc && item.opcode == tcc_pkg::OP_OPEN), ctx.done)

endmodule
`default_nettype wire

@@ verif/tcc_checker.sv @@
// Checker for the TCP client connection block: connection predictor and segment comparison.
`default_nettype none
module tcc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic        opcode,
  input  logic        in_syn,
  input  logic        in_ack_flag,
  input  logic        in_fin,
  input  logic [31:0] in_seq,
  input  logic [31:0] in_ack_num,
  input  logic [10:0] in_payload_len,
  input  logic [15:0] in_dest_port,
  input  logic        seg_valid,
  input  logic        seg_ready,
  input  logic        out_syn,
  input  logic        out_ack,
  input  logic        out_fin,
  input  logic        out_psh,
  input  logic [31:0] out_seq,
  input  logic [31:0] out_ack_num,
  input  logic [10:0] out_payload_len,
  input  logic        out_last,
  input  logic        finished,
  input  logic [3:0]  conn_state,
  output int          errors,
  output int          outstanding,
  output int          segs_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  cfg_t        regs;
  logic [3:0]  conn_st;
  logic [31:0] tx_seq;
  logic [31:0] fin_mark;
  logic [31:0] rx_next;
  logic [31:0] peer_ack;
  logic [5:0]  steps;
  logic        conn_done;
  beat_t       segs_due[$];
  beat_t       step_segs[$];

  initial begin
    errors = 0;
    outstanding = 0;
    segs_checked = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t MISMATCH segment %0d %s: got %0h expected %0h",
             $realtime, segs_checked, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic void emit_segment(input logic syn, input logic fin, input logic psh);
    beat_t       b;
    logic [31:0] after;
    b = '0;
    b.out_syn = syn;
    b.out_ack = !syn;
    b.out_fin = fin;
    b.out_psh = psh;
    b.out_seq = tx_seq;
    b.out_ack_num = rx_next;
    b.out_payload_len = psh ? regs.request_length : 11'd0;
    after = tx_seq;
    if (syn) after = after + 32'd1;
    if (fin) begin
      after = after + 32'd1;
      fin_mark = after;
    end
    if (psh) after = after + {21'd0, regs.request_length};
    tx_seq = after;
    step_segs.push_back(b);
  endfunction

  function automatic void step_fsm(input logic s, input logic a, input logic f);
    case (conn_st)
      ST_SYN_SENT: begin
        if (s && a) begin
          emit_segment(1'b0, 1'b0, 1'b0);
          conn_st = ST_ESTABLISHED;
          emit_segment(1'b0, 1'b0, 1'b1);
        end else if (s) begin
          conn_st = ST_SYN_RECEIVED;
          emit_segment(1'b0, 1'b0, 1'b0);
        end
      end
      ST_SYN_RECEIVED: begin
        if (a) begin
          conn_st = ST_ESTABLISHED;
          emit_segment(1'b0, 1'b0, 1'b1);
        end
      end
      ST_ESTABLISHED: begin
        if (f) begin
          conn_st = ST_CLOSE_WAIT;
          emit_segment(1'b0, 1'b1, 1'b0);
        end else if (peer_ack <= regs.initial_seq + 32'd1) begin
          emit_segment(1'b0, 1'b0, 1'b1);
        end else begin
          conn_st = ST_FIN_WAIT1;
          emit_segment(1'b0, 1'b1, 1'b0);
        end
      end
      ST_FIN_WAIT1: begin
        if (f) begin
          conn_st = ST_CLOSING;
          emit_segment(1'b0, 1'b0, 1'b0);
        end else if (peer_ack > fin_mark) begin
          conn_st = ST_FIN_WAIT2;
        end
      end
      ST_FIN_WAIT2: begin
        if (f) conn_st = ST_TIME_WAIT;
        emit_segment(1'b0, 1'b0, 1'b0);
      end
      ST_CLOSE_WAIT: begin
        conn_st = ST_LAST_ACK;
        emit_segment(1'b0, 1'b1, 1'b0);
      end
      ST_LAST_ACK: begin
        if (a) conn_st = ST_CLOSED;
      end
      default: ;
    endcase
  endfunction

  function automatic void finish_step();
    beat_t b;
    steps = steps + 6'd1;
    if (conn_st == ST_TIME_WAIT || conn_st == ST_CLOSED || conn_st == ST_CLOSING ||
        steps >= regs.max_tries)
      conn_done = 1'b1;
    foreach (step_segs[k]) begin
      b = step_segs[k];
      b.out_last = (k == step_segs.size() - 1);
      b.finished = conn_done;
      b.conn_state = conn_st;
      segs_due.push_back(b);
    end
    step_segs.delete();
  endfunction

  function automatic void predict_item(input item_t it);
    step_segs.delete();
    if (it.opcode == OP_OPEN) begin
      if (conn_st != ST_START && !conn_done) return;
      conn_st = ST_SYN_SENT;
      tx_seq = regs.initial_seq;
      fin_mark = '0;
      rx_next = '0;
      peer_ack = '0;
      steps = '0;
      conn_done = 1'b0;
      emit_segment(1'b1, 1'b0, 1'b0);
      finish_step();
      return;
    end
    if (conn_st == ST_START || conn_done || it.in_dest_port != regs.local_port) return;
    rx_next = it.in_seq + {21'd0, it.in_payload_len} + {31'd0, it.in_syn} +
              {31'd0, it.in_fin};
    if (it.in_ack_flag) begin
      peer_ack = it.in_ack_num;
      tx_seq = it.in_ack_num;
    end
    step_fsm(it.in_syn, it.in_ack_flag, it.in_fin);
    finish_step();
  endfunction

  always @(posedge clk) begin
    beat_t want;
    item_t it;
    if (rst) begin
      regs.local_port = RST_LOCAL_PORT;
      regs.initial_seq = '0;
      regs.request_length = RST_REQUEST_LENGTH;
      regs.max_tries = RST_MAX_TRIES;
      conn_st = ST_START;
      tx_seq = '0;
      fin_mark = '0;
      rx_next = '0;
      peer_ack = '0;
      steps = '0;
      conn_done = 1'b0;
      segs_due.delete();
    end else begin
      if (seg_valid && seg_ready) begin
        if (segs_due.size() == 0) begin
          report_mismatch("beat with nothing expected, seq", out_seq, '0);
        end else begin
          want = segs_due.pop_front();
          check_field("syn", 32'(out_syn), 32'(want.out_syn));
          check_field("ack", 32'(out_ack), 32'(want.out_ack));
          check_field("fin", 32'(out_fin), 32'(want.out_fin));
          check_field("psh", 32'(out_psh), 32'(want.out_psh));
          check_field("seq", out_seq, want.out_seq);
          check_field("ack_num", out_ack_num, want.out_ack_num);
          check_field("payload_len", 32'(out_payload_len), 32'(want.out_payload_len));
          check_field("last", 32'(out_last), 32'(want.out_last));
          check_field("finished", 32'(finished), 32'(want.finished));
          check_field("conn_state", 32'(conn_state), 32'(want.conn_state));
        end
        segs_checked++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LOCAL_PORT:     regs.local_port = cfg_data[15:0];
          REG_INITIAL_SEQ:    regs.initial_seq = cfg_data;
          REG_REQUEST_LENGTH: regs.request_length = cfg_data[10:0];
          REG_MAX_TRIES:      regs.max_tries = cfg_data[5:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        it = '{opcode, in_syn, in_ack_flag, in_fin, in_seq, in_ack_num, in_payload_len,
               in_dest_port};
        predict_item(it);
      end
    end
    outstanding <= segs_due.size();
  end

endmodule
`default_nettype wire

@@ verif/tcp_client_connection_fsm_top_tb.sv @@
// Testbench top for the TCP client connection block: stimulus, register phases, verdict.
`default_nettype none
module tcp_client_connection_fsm_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  localparam int STALL_LIMIT = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_LOCAL_PORT;
  logic [31:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  item_t       cur_item = '0;
  logic        seg_ready = 1'b0;
  logic        gaps_on = 1'b1;
  int          stall_left = 0;

  logic        item_ready;
  logic        seg_valid;
  logic        out_syn;
  logic        out_ack;
  logic        out_fin;
  logic        out_psh;
  logic [31:0] out_seq;
  logic [31:0] out_ack_num;
  logic [10:0] out_payload_len;
  logic        out_last;
  logic        finished;
  logic [3:0]  conn_state;
  int          errors;
  int          outstanding;
  int          segs_checked;

  logic [15:0] cur_port = RST_LOCAL_PORT;
  logic [31:0] cur_iseq = '0;
  logic [31:0] cur_rlen = {21'd0, RST_REQUEST_LENGTH};
  logic [31:0] rx_cursor = '0;
  bit          noisy = 1'b0;
  int          beats_sent = 0;
  int          script_items = 0;
  int          conns_opened = 0;

  tcp_client_connection_fsm_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready),
    .opcode(cur_item.opcode), .in_syn(cur_item.in_syn), .in_ack_flag(cur_item.in_ack_flag),
    .in_fin(cur_item.in_fin), .in_seq(cur_item.in_seq), .in_ack_num(cur_item.in_ack_num),
    .in_payload_len(cur_item.in_payload_len), .in_dest_port(cur_item.in_dest_port),
    .seg_valid(seg_valid), .seg_ready(seg_ready),
    .out_syn(out_syn), .out_ack(out_ack), .out_fin(out_fin), .out_psh(out_psh),
    .out_seq(out_seq), .out_ack_num(out_ack_num), .out_payload_len(out_payload_len),
    .out_last(out_last), .finished(finished), .conn_state(conn_state)
  );

  tcc_checker audit (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready),
    .opcode(cur_item.opcode), .in_syn(cur_item.in_syn), .in_ack_flag(cur_item.in_ack_flag),
    .in_fin(cur_item.in_fin), .in_seq(cur_item.in_seq), .in_ack_num(cur_item.in_ack_num),
    .in_payload_len(cur_item.in_payload_len), .in_dest_port(cur_item.in_dest_port),
    .seg_valid(seg_valid), .seg_ready(seg_ready),
    .out_syn(out_syn), .out_ack(out_ack), .out_fin(out_fin), .out_psh(out_psh),
    .out_seq(out_seq), .out_ack_num(out_ack_num), .out_payload_len(out_payload_len),
    .out_last(out_last), .finished(finished), .conn_state(conn_state),
    .errors(errors), .outstanding(outstanding), .segs_checked(segs_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!gaps_on) begin
      seg_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      seg_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      seg_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      seg_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (seg_valid && seg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [10:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return 11'd0;
      1:       return 11'd1460;
      2, 3, 4: return 11'($urandom_range(0, 1460));
      default: return 11'($urandom_range(0, 64));
    endcase
  endfunction

  function automatic logic [31:0] pick_ack(input logic [31:0] base);
    case ($urandom_range(0, 5))
      0:       return base;
      1:       return base - 32'd1;
      2:       return base + cur_rlen;
      3:       return base + cur_rlen + 32'd1;
      4:       return base + cur_rlen + 32'd2;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid <= 1'b1;
    cur_item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic noise_item();
    item_t it;
    it.opcode = OP_SEGMENT;
    it.in_syn = 1'($urandom);
    it.in_ack_flag = 1'($urandom);
    it.in_fin = 1'($urandom);
    it.in_seq = $urandom;
    it.in_ack_num = $urandom;
    it.in_payload_len = pick_len();
    it.in_dest_port = cur_port;
    case ($urandom_range(0, 2))
      0:       it.opcode = OP_OPEN;
      1:       it.in_dest_port = cur_port ^ 16'($urandom_range(1, 65535));
      default: ;
    endcase
    push_item(it);
  endtask

  task automatic open_conn();
    item_t it;
    it.opcode = OP_OPEN;
    it.in_syn = 1'($urandom);
    it.in_ack_flag = 1'($urandom);
    it.in_fin = 1'($urandom);
    it.in_seq = $urandom;
    it.in_ack_num = $urandom;
    it.in_payload_len = pick_len();
    it.in_dest_port = 16'($urandom);
    rx_cursor = $urandom;
    push_item(it);
    script_items++;
    conns_opened++;
  endtask

  task automatic segment(input bit s, input bit a, input bit f, input logic [31:0] ackn);
    item_t it;
    if (noisy && $urandom_range(0, 9) == 0) noise_item();
    it.opcode = OP_SEGMENT;
    it.in_syn = s;
    it.in_ack_flag = a;
    it.in_fin = f;
    it.in_seq = rx_cursor;
    it.in_ack_num = ackn;
    it.in_payload_len = pick_len();
    it.in_dest_port = cur_port;
    rx_cursor = rx_cursor + {21'd0, it.in_payload_len} + {31'd0, s} + {31'd0, f};
    push_item(it);
    script_items++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] port, input logic [31:0] iseq,
                          input logic [10:0] rlen, input logic [5:0] tries);
    cfg_we <= 1'b1;
    cfg_index <= REG_LOCAL_PORT;
    cfg_data <= {16'd0, port};
    @(posedge clk);
    cfg_index <= REG_INITIAL_SEQ;
    cfg_data <= iseq;
    @(posedge clk);
    cfg_index <= REG_REQUEST_LENGTH;
    cfg_data <= {21'd0, rlen};
    @(posedge clk);
    cfg_index <= REG_MAX_TRIES;
    cfg_data <= {26'd0, tries};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_port = port;
    cur_iseq = iseq;
    cur_rlen = {21'd0, rlen};
  endtask

  task automatic run_connection();
    logic [31:0] base;
    base = cur_iseq + 32'd1;
    open_conn();
    // free-running peer
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 10))
        segment($urandom_range(0, 2) == 0, $urandom_range(0, 3) != 0,
                $urandom_range(0, 3) == 0, pick_ack(base));
      return;
    end
    if ($urandom_range(0, 1) == 0) begin
      segment(1'b1, 1'b1, 1'b0, base);
    end else begin
      segment(1'b1, 1'b0, 1'b0, $urandom);
      segment(1'b0, 1'b1, 1'b0, base);
    end
    repeat ($urandom_range(0, 2)) segment(1'b0, 1'($urandom), 1'b0, base);
    if ($urandom_range(0, 1) == 0) begin
      // active close: request acked, FIN out
      segment(1'b0, 1'b1, 1'b0, base + cur_rlen);
      if ($urandom_range(0, 2) == 0) begin
        segment(1'b0, 1'($urandom), 1'b1, base + cur_rlen + 32'd1);
      end else begin
        if ($urandom_range(0, 1) == 0) segment(1'b0, 1'b1, 1'b0, base + cur_rlen + 32'd1);
        segment(1'b0, 1'b1, 1'b0, base + cur_rlen + 32'd2);
        repeat ($urandom_range(0, 2)) segment(1'b0, 1'b1, 1'b0, base + cur_rlen + 32'd2);
        segment(1'b0, 1'($urandom), 1'b1, base + cur_rlen + 32'd2);
      end
    end else begin
      // peer closes first
      segment(1'b0, 1'b1, 1'b1, base);
      segment(1'b0, 1'($urandom), 1'b0, base + 32'd1);
      if ($urandom_range(0, 1) == 0) segment(1'b0, 1'b0, 1'b0, $urandom);
      segment(1'b0, 1'b1, 1'b0, $urandom);
    end
  endtask

  initial begin
    item_t       ext;
    logic [15:0] p;
    logic [31:0] iq;
    logic [10:0] rl;
    logic [5:0]  mt;
    int          budget;
    int          target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    segment(1'b1, 1'b1, 1'b0, 32'd1);
    open_conn();
    open_conn();
    ext = '{OP_SEGMENT, 1'b1, 1'b1, 1'b1, '1, '1, 11'd1460, 16'hFFFF};
    push_item(ext);
    segment(1'b1, 1'b0, 1'b0, 32'd0);
    segment(1'b0, 1'b1, 1'b0, 32'd1);
    ext = '{OP_SEGMENT, 1'b0, 1'b0, 1'b0, '1, '1, 11'd1460, cur_port};
    push_item(ext);
    segment(1'b0, 1'b1, 1'b0, 32'd46);
    segment(1'b0, 1'b1, 1'b0, 32'd47);
    segment(1'b0, 1'b1, 1'b0, 32'd48);
    segment(1'b0, 1'b1, 1'b0, 32'd48);
    segment(1'b0, 1'b0, 1'b1, 32'd0);
    segment(1'b0, 1'b1, 1'b0, 32'd0);
    open_conn();
    segment(1'b1, 1'b1, 1'b0, 32'd1);
    segment(1'b0, 1'b1, 1'b1, 32'd1);
    segment(1'b0, 1'b1, 1'b0, 32'd2);
    segment(1'b0, 1'b0, 1'b0, 32'd0);
    segment(1'b0, 1'b1, 1'b0, 32'd2);
    open_conn();
    segment(1'b1, 1'b1, 1'b0, 32'd1);
    segment(1'b0, 1'b1, 1'b0, 32'd46);
    segment(1'b0, 1'b0, 1'b1, 32'd0);
    open_conn();
    segment(1'b1, 1'b1, 1'b0, 32'd1);
    settle();
    // initial_seq moved under a live connection
    set_regs(RST_LOCAL_PORT, 32'd100, RST_REQUEST_LENGTH, RST_MAX_TRIES);
    segment(1'b0, 1'b1, 1'b0, 32'd1);
    settle();
    set_regs(RST_LOCAL_PORT, 32'd0, RST_REQUEST_LENGTH, 6'd0);
    segment(1'b0, 1'b1, 1'b0, 32'd1);
    open_conn();
    segment(1'b1, 1'b1, 1'b0, 32'd1);
    settle();

    noisy = 1'b1;
    for (int ph = 0; ph < 7; ph++) begin
      p = 16'($urandom);
      iq = $urandom;
      rl = 11'($urandom_range(0, 1460));
      mt = 6'($urandom_range(4, 63));
      budget = 250;
      case (ph)
        0: begin
          p = RST_LOCAL_PORT;
          iq = '0;
          rl = RST_REQUEST_LENGTH;
          mt = RST_MAX_TRIES;
          budget = 200;
        end
        1: begin
          p = '0;
          iq = '1;
          rl = 11'd1460;
          mt = 6'd63;
        end
        2: begin
          p = '1;
          iq = '0;
          rl = '0;
          mt = 6'd1;
          budget = 60;
        end
        3: begin
          iq = 32'hFFFF_FFFE;
          mt = 6'($urandom_range(2, 5));
          budget = 150;
        end
        6:       gaps_on <= 1'b0;
        default: budget = 300;
      endcase
      set_regs(p, iq, rl, mt);
      target = script_items + budget;
      while (script_items < target) run_connection();
      settle();
    end
    repeat (16) @(posedge clk);

    $display("Drove %0d input beats across %0d connection opens and 9 register settings;",
             beats_sent, conns_opened);
    $display("%0d segments compared, %0d mismatches.", segs_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ tcp_client_connection_fsm_top.f @@
+incdir+design
design/tcc_pkg.sv
design/tcc_step.sv
design/tcc_out_fifo.sv
design/tcp_client_connection_fsm_top.sv
verif/tcc_checker.sv
verif/tcp_client_connection_fsm_top_tb.sv
